@@ sv/tsst_pkg.sv @@
// ----------------------------------------------------------------------------
// tsst_pkg
// Types and constants used by the token scanner.
// ----------------------------------------------------------------------------
package tsst_pkg;

    // Character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    // Token kinds
    localparam logic [3:0] KIND_END        = 4'd0;
    localparam logic [3:0] KIND_WORD       = 4'd1;
    localparam logic [3:0] KIND_VAR        = 4'd2;
    localparam logic [3:0] KIND_NUM        = 4'd3;
    localparam logic [3:0] KIND_PLUS       = 4'd4;
    localparam logic [3:0] KIND_PLUS_ASSIGN = 4'd5;
    localparam logic [3:0] KIND_AT         = 4'd6;
    localparam logic [3:0] KIND_AT_USCORE  = 4'd7;
    localparam logic [3:0] KIND_ASSIGN     = 4'd8;
    localparam logic [3:0] KIND_CHAR       = 4'd9;
    localparam logic [3:0] KIND_DOLLAR     = 4'd10;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PLUS,
        M_AT,
        M_WORD,
        M_NUM,
        M_DOLLAR,
        M_COMMENT
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_RD,
        ST_CMP,
        ST_INS,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  char_code;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
        logic [4:0]  sym_index;
        logic        new_entry;
        logic [1:0]  error;
    } result_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

@@ sv/tsst_ifs.sv @@
// ----------------------------------------------------------------------------
// tsst channel interfaces
// Character request channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface tsst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  char_code;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
    logic [4:0]  sym_index;
    logic        new_entry;
    logic [1:0]  error;
    logic        last;

    modport source (output valid, output kind, output char_code, output line,
                    output column, output length, output sym_index,
                    output new_entry, output error, output last, input ready);
    modport sink   (input valid, input kind, input char_code, input line,
                    input column, input length, input sym_index,
                    input new_entry, input error, input last, output ready);
endinterface

@@ sv/token_scanner_symbol_table_top.sv @@
// ----------------------------------------------------------------------------
// token_scanner_symbol_table_top
// Character-at-a-time scanner with a symbol table for '$name' variables.
// ----------------------------------------------------------------------------
// One request carries one character (or the end-of-input mark) and yields
// zero, one or two tokens. The block takes a request, then offers its tokens
// one per cycle while the output is ready, and takes the next request in the
// cycle after the last token is taken. A variable that closes is looked up
// by a single byte comparator that walks the table: it checks each entry's
// stored length, compares the name byte by byte in an entry whose length
// matches and, on first sight, copies the name byte by byte into the name
// memory. Names longer than NAME_LEN letters are cut and flagged; a full
// table gives index 0 and the full flag. Line, column and table survive an
// end token; only reset clears them.
// ----------------------------------------------------------------------------
module token_scanner_symbol_table_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int NAME_LEN    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    tsst_in_if.sink      in_chan,
    tsst_out_if.source   out_chan
);
    import tsst_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH + 1);              // entry count
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(NAME_LEN);                     // byte index
    localparam int LW = $clog2(NAME_LEN + 1);                 // name length
    localparam int MD = TABLE_DEPTH * NAME_LEN;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    // Control state
    state_t          state_reg, state_next;
    mode_t           mode_reg, mode_next;
    logic [15:0]     line_reg, line_next;
    logic [15:0]     col_reg, col_next;
    logic [15:0]     ts_reg, ts_next;
    logic [7:0]      tl_reg, tl_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [NW-1:0]   pos_reg, pos_next;
    logic [LW-1:0]   keep_reg, keep_next;
    logic            trunc_reg, trunc_next;
    logic [1:0]      nres_reg, nres_next;
    logic            oidx_reg, oidx_next;

    // Payload
    result_t         res_reg [2];
    result_t         r0, r1;
    logic            load_res, patch_var;
    logic [4:0]      patch_idx;
    logic            patch_new;
    logic [1:0]      patch_err;

    // Storage
    logic [7:0]      nbuf [NAME_LEN];
    logic [LW-1:0]   lens [TABLE_DEPTH];
    logic [7:0]      names_mem [MD];
    logic [7:0]      rd_q;
    logic [AW-1:0]   mem_addr;
    logic            mem_we, len_we, nb_we;
    logic [NW-1:0]   nb_addr;

    // Step logic
    logic            accept;
    logic [7:0]      c;
    logic [15:0]     col_inc;
    logic            fl_v, fl_var, fl_take, do_idle, idle_v;
    result_t         fl_r, idle_r;
    logic [7:0]      letters;
    logic [7:0]      dpos;

    assign accept  = in_chan.valid && in_chan.ready;
    assign c       = in_chan.ch;
    assign col_inc = sat_inc16(col_reg);
    assign letters = tl_reg - 8'd1;
    assign dpos    = tl_reg - 8'd1;

    // Token that the pending mode would give if closed now
    always_comb
    begin
        fl_v   = 1'b1;
        fl_var = 1'b0;
        fl_r   = '0;
        fl_r.line   = line_reg;
        fl_r.column = ts_reg;
        fl_r.length = 8'd1;
        unique case (mode_reg)
            M_PLUS:   fl_r.kind = KIND_PLUS;
            M_AT:     fl_r.kind = KIND_AT;
            M_WORD:
            begin
                fl_r.kind   = KIND_WORD;
                fl_r.length = tl_reg;
            end
            M_NUM:
            begin
                fl_r.kind   = KIND_NUM;
                fl_r.length = tl_reg;
            end
            M_DOLLAR:
            begin
                if (tl_reg <= 8'd1)
                begin
                    fl_r.kind = KIND_DOLLAR;
                end
                else
                begin
                    fl_r.kind   = KIND_VAR;
                    fl_r.length = tl_reg;
                    fl_var      = 1'b1;
                end
            end
            default:  fl_v = 1'b0;
        endcase
    end

    // Scanner step for one character
    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        ts_next   = ts_reg;
        tl_next   = tl_reg;
        fl_take   = 1'b0;
        do_idle   = 1'b0;
        idle_v    = 1'b0;
        idle_r    = '0;
        idle_r.line   = line_reg;
        idle_r.column = col_inc;
        idle_r.length = 8'd1;
        nb_we     = 1'b0;
        nb_addr   = dpos[NW-1:0];

        if (in_chan.end_of_input)
        begin
            fl_take       = fl_v;
            mode_next     = M_IDLE;
            idle_v        = 1'b1;
            idle_r.kind   = KIND_END;
            idle_r.length = 8'd0;
        end
        else
        begin
            unique case (mode_reg)
                M_COMMENT:
                begin
                    if (c == CH_NL)
                    begin
                        mode_next = M_IDLE;
                        do_idle   = 1'b1;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
                M_PLUS, M_AT:
                begin
                    mode_next = M_IDLE;
                    if ((mode_reg == M_PLUS && c == CH_EQ) ||
                        (mode_reg == M_AT && c == CH_USCORE))
                    begin
                        idle_v        = 1'b1;
                        idle_r.kind   = (mode_reg == M_PLUS) ? KIND_PLUS_ASSIGN
                                                             : KIND_AT_USCORE;
                        idle_r.column = ts_reg;
                        idle_r.length = 8'd2;
                        col_next      = col_inc;
                    end
                    else
                    begin
                        fl_take = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_WORD, M_NUM:
                begin
                    if ((mode_reg == M_WORD && is_alpha(c)) ||
                        (mode_reg == M_NUM && is_digit(c)))
                    begin
                        if (tl_reg != 8'hFF)
                            tl_next = tl_reg + 8'd1;
                        col_next = col_inc;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        fl_take   = 1'b1;
                        do_idle   = 1'b1;
                    end
                end
                M_DOLLAR:
                begin
                    if (is_alpha(c))
                    begin
                        nb_we = (dpos < 8'(NAME_LEN));
                        if (tl_reg != 8'hFF)
                            tl_next = tl_reg + 8'd1;
                        col_next = col_inc;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        fl_take   = 1'b1;
                        do_idle   = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                    do_idle   = 1'b1;
                end
            endcase

            if (do_idle)
            begin
                if (c == CH_NL)
                begin
                    line_next = sat_inc16(line_reg);
                    col_next  = 16'd0;
                end
                else
                begin
                    col_next = col_inc;
                    if (c == CH_SPACE || c == CH_TAB)
                    begin
                        // drop whitespace
                    end
                    else if (c == CH_HASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else if (c == CH_EQ)
                    begin
                        idle_v      = 1'b1;
                        idle_r.kind = KIND_ASSIGN;
                    end
                    else if (c == CH_PLUS || c == CH_AT || c == CH_DOLLAR ||
                             is_alpha(c) || is_digit(c))
                    begin
                        ts_next = col_inc;
                        tl_next = 8'd1;
                        if (c == CH_PLUS)
                            mode_next = M_PLUS;
                        else if (c == CH_AT)
                            mode_next = M_AT;
                        else if (c == CH_DOLLAR)
                            mode_next = M_DOLLAR;
                        else if (is_alpha(c))
                            mode_next = M_WORD;
                        else
                            mode_next = M_NUM;
                    end
                    else
                    begin
                        idle_v           = 1'b1;
                        idle_r.kind      = KIND_CHAR;
                        idle_r.char_code = c;
                    end
                end
            end
        end

        r0 = (fl_take && fl_v) ? fl_r : idle_r;
        r1 = idle_r;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        keep_next  = keep_reg;
        trunc_next = trunc_reg;
        nres_next  = nres_reg;
        oidx_next  = oidx_reg;
        load_res   = 1'b0;
        patch_var  = 1'b0;
        patch_idx  = '0;
        patch_new  = 1'b0;
        patch_err  = ERR_NONE;
        mem_we     = 1'b0;
        len_we     = 1'b0;
        mem_addr   = AW'(idx_reg[TW-1:0]) * AW'(NAME_LEN) + AW'(pos_reg);
        in_chan.ready  = (state_reg == ST_IDLE);
        out_chan.valid = (state_reg == ST_OUT);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_res   = 1'b1;
                    nres_next  = 2'((fl_take && fl_v) ? 1 : 0) + 2'(idle_v ? 1 : 0);
                    oidx_next  = 1'b0;
                    idx_next   = '0;
                    keep_next  = (letters > 8'(NAME_LEN)) ? LW'(NAME_LEN)
                                                          : LW'(letters);
                    trunc_next = (letters > 8'(NAME_LEN));
                    if (fl_take && fl_var)
                        state_next = ST_LEN;
                    else if (fl_take && fl_v || idle_v)
                        state_next = ST_OUT;
                end
            end
            ST_LEN:
            begin
                // check one entry's stored length, or end of table
                pos_next = '0;
                if (idx_reg == cnt_reg)
                begin
                    if (cnt_reg < IW'(TABLE_DEPTH))
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        patch_var  = 1'b1;
                        patch_err  = ERR_FULL;
                        state_next = ST_OUT;
                    end
                end
                else if (lens[idx_reg[TW-1:0]] == keep_reg)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rd_q != nbuf[pos_reg])
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_LEN;
                end
                else if (LW'(pos_reg) + LW'(1) == keep_reg)
                begin
                    patch_var  = 1'b1;
                    patch_idx  = 5'(idx_reg + IW'(1));
                    patch_err  = trunc_reg ? ERR_TRUNC : ERR_NONE;
                    state_next = ST_OUT;
                end
                else
                begin
                    pos_next   = pos_reg + NW'(1);
                    state_next = ST_RD;
                end
            end
            ST_INS:
            begin
                // copy the name into the next free entry, one byte a cycle
                mem_we = 1'b1;
                if (LW'(pos_reg) + LW'(1) == keep_reg)
                begin
                    len_we     = 1'b1;
                    cnt_next   = cnt_reg + IW'(1);
                    patch_var  = 1'b1;
                    patch_idx  = 5'(cnt_reg + IW'(1));
                    patch_new  = 1'b1;
                    patch_err  = trunc_reg ? ERR_TRUNC : ERR_NONE;
                    state_next = ST_OUT;
                end
                else
                begin
                    pos_next = pos_reg + NW'(1);
                end
            end
            ST_OUT:
            begin
                if (out_chan.ready)
                begin
                    if (2'(oidx_reg) + 2'd1 >= nres_reg)
                        state_next = ST_IDLE;
                    else
                        oidx_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= M_IDLE;
            line_reg  <= 16'd1;
            col_reg   <= 16'd0;
            ts_reg    <= 16'd0;
            tl_reg    <= 8'd0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            keep_reg  <= '0;
            trunc_reg <= 1'b0;
            nres_reg  <= 2'd0;
            oidx_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            keep_reg  <= keep_next;
            trunc_reg <= trunc_next;
            nres_reg  <= nres_next;
            oidx_reg  <= oidx_next;
            if (accept)
            begin
                mode_reg <= mode_next;
                line_reg <= line_next;
                col_reg  <= col_next;
                ts_reg   <= ts_next;
                tl_reg   <= tl_next;
            end
        end
    end

    // Result registers and table storage
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg[0] <= r0;
            res_reg[1] <= r1;
        end
        else if (patch_var)
        begin
            res_reg[0].sym_index <= patch_idx;
            res_reg[0].new_entry <= patch_new;
            res_reg[0].error     <= patch_err;
        end
        if (accept && nb_we)
            nbuf[nb_addr] <= c;
        if (len_we)
            lens[cnt_reg[TW-1:0]] <= keep_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            names_mem[AW'(cnt_reg[TW-1:0]) * AW'(NAME_LEN) + AW'(pos_reg)] <= nbuf[pos_reg];
        rd_q <= names_mem[mem_addr];
    end

    assign out_chan.kind      = res_reg[oidx_reg].kind;
    assign out_chan.char_code = res_reg[oidx_reg].char_code;
    assign out_chan.line      = res_reg[oidx_reg].line;
    assign out_chan.column    = res_reg[oidx_reg].column;
    assign out_chan.length    = res_reg[oidx_reg].length;
    assign out_chan.sym_index = res_reg[oidx_reg].sym_index;
    assign out_chan.new_entry = res_reg[oidx_reg].new_entry;
    assign out_chan.error     = res_reg[oidx_reg].error;
    assign out_chan.last      = (2'(oidx_reg) + 2'd1 == nres_reg);

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_chan.ready && out_chan.valid))
        else $error("request taken while a token is offered");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= IW'(TABLE_DEPTH))
        else $error("symbol count beyond table depth");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_chan.end_of_input) |=> (mode_reg == M_IDLE))
        else $error("scanner not idle after end of input");

    a_last_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && out_chan.ready && out_chan.last) |=> in_chan.ready)
        else $error("not ready after last token");
`endif

endmodule
